// ===== rtl/core/rchop_pkg.sv =====
// ----------------------------------------------------------------------------
// rchop_pkg
// Shared widths, register indexes and the hop channel table of the
// frequency-hopping packet transmitter.
// ----------------------------------------------------------------------------
package rchop_pkg;

  localparam int unsigned ChanW       = 15;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned NumChan     = 8;
  localparam int unsigned PacketLen   = 21;
  localparam int unsigned HeaderLen   = 5;

  typedef logic signed [ChanW-1:0] chan_t;

  localparam logic [CfgIdxW-1:0] RegDeviceId       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFixedIdSet     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegActiveChannels = 3'd2;
  localparam logic [CfgIdxW-1:0] RegModMode        = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBindCount      = 3'd4;

  localparam logic [7:0] HdrBind = 8'hAA;
  localparam logic [7:0] HdrData = 8'h55;

  localparam logic [7:0] HopTable [256] = '{
    8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0,
    8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a,
    8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82,
    8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,
    8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,
    8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28,
    8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64,
    8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,
    8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64,
    8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50,
    8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,
    8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46
  };

endpackage

// ===== rtl/core/rchop_item_if.sv =====
// ----------------------------------------------------------------------------
// rchop_item_if
// Input item channel: start or slot tick with eight channel values.
// ----------------------------------------------------------------------------
interface rchop_item_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 bind_request;
  rchop_pkg::chan_t     channel_0;
  rchop_pkg::chan_t     channel_1;
  rchop_pkg::chan_t     channel_2;
  rchop_pkg::chan_t     channel_3;
  rchop_pkg::chan_t     channel_4;
  rchop_pkg::chan_t     channel_5;
  rchop_pkg::chan_t     channel_6;
  rchop_pkg::chan_t     channel_7;

  modport source (
    output valid, kind, bind_request, channel_0, channel_1, channel_2, channel_3,
           channel_4, channel_5, channel_6, channel_7,
    input  ready
  );
  modport sink (
    input  valid, kind, bind_request, channel_0, channel_1, channel_2, channel_3,
           channel_4, channel_5, channel_6, channel_7,
    output ready
  );
endinterface

// ===== rtl/core/rchop_pkt_if.sv =====
// ----------------------------------------------------------------------------
// rchop_pkt_if
// Output channel: one packet byte per transfer with its packet attributes.
// ----------------------------------------------------------------------------
interface rchop_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [rchop_pkg::ByteW-1:0]   packet_byte;
  logic [rchop_pkg::PosW-1:0]    byte_position;
  logic [7:0]                    radio_channel;
  logic                          last_byte;
  logic                          bind_finished;
  logic                          power_refresh;

  modport source (
    output valid, packet_byte, byte_position, radio_channel, last_byte,
           bind_finished, power_refresh,
    input  ready
  );
  modport sink (
    input  valid, packet_byte, byte_position, radio_channel, last_byte,
           bind_finished, power_refresh,
    output ready
  );
endinterface

// ===== rtl/core/rchop_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rchop_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rchop_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rchop_pkg::CfgIdxW-1:0]    index;
  logic [rchop_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rc_hopping_packet_transmitter.sv =====
// ----------------------------------------------------------------------------
// rc_hopping_packet_transmitter
// Frequency-hopping radio control packet transmitter: builds a 21-byte
// packet per slot tick with one shared reciprocal multiply unit.
// ----------------------------------------------------------------------------
//  channel  | dir | modport | contents
//  item_i   | in  | sink    | kind, bind_request, channel_0..channel_7
//  pkt_o    | out | source  | packet_byte, byte_position, radio_channel, flags
//  cfg_i    | in  | sink    | index, data (always ready)
//
//  start item: no output
//  slot tick: 5 header writes, then per channel 1 multiply + 1 clamp
//  + 2 byte writes, then each of the 21 bytes is read and sent out
//  the registered read of each stored byte sets the send time
//  rst_ni clears all control state; configuration registers take their defaults
//  item_i.ready is low while a packet is built or sent; pkt_o stalls hold it
// ----------------------------------------------------------------------------
module rc_hopping_packet_transmitter #(
  parameter int unsigned CHAN_FULL_SCALE = 10000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rchop_item_if.sink           item_i,
  rchop_pkt_if.source          pkt_o,
  rchop_cfg_if.sink            cfg_i
);

  localparam int unsigned ProdW  = 23;
  localparam int unsigned MagW   = 15;
  localparam int unsigned RecipW = 25;
  localparam int unsigned MulW   = MagW + RecipW;
  localparam int unsigned Shift  = MagW + $clog2(CHAN_FULL_SCALE);
  // ceiling of gain * 2^Shift / full scale, exact for every 15-bit magnitude
  localparam logic [63:0] RecipFull =
    ((64'd497 << Shift) + 64'(CHAN_FULL_SCALE) - 64'd1) / 64'(CHAN_FULL_SCALE);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
  localparam logic [rchop_pkg::PosW-1:0] LastPos = 5'(rchop_pkg::PacketLen - 1);
  localparam logic [rchop_pkg::PosW-1:0] HdrLast = 5'(rchop_pkg::HeaderLen - 1);
  localparam logic [rchop_pkg::PosW-1:0] FlagByteA = 5'd10;
  localparam logic [rchop_pkg::PosW-1:0] FlagByteB = 5'd12;

  typedef enum logic [3:0] {
    StIdle, StHdr, StMul, StFin, StWlo, StWhi, StRd, StOut
  } state_e;

  state_e                         state_q;
  logic [31:0]                    id_q;
  logic                           fixed_q;
  logic [3:0]                     active_q;
  logic                           mod_q;
  logic [15:0]                    bind_count_q;
  logic [3:0]                     row_q, col_q, off_q;
  logic [15:0]                    bind_left_q;
  rchop_pkg::chan_t               ch_q [rchop_pkg::NumChan];
  logic                           bind_q, fin_q, ref_q;
  logic [7:0]                     chan_q;
  logic [rchop_pkg::PosW-1:0]     idx_q;
  logic [2:0]                     ch_idx_q;
  logic [ProdW-1:0]               prod_q;
  logic                           neg_q;
  logic [15:0]                    word_q;
  logic [7:0]                     rd_q;
  logic [7:0]                     mem [rchop_pkg::PacketLen];

  logic                           item_xfer, pkt_xfer, cfg_xfer;
  rchop_pkg::chan_t               ch_sel;
  logic [14:0]                    mag;
  logic [MulW-1:0]                prod_full;
  logic signed [24:0]             q_s, v_s;
  logic [15:0]                    word_d;
  logic                           blank;
  logic                           we;
  logic [7:0]                     wbase, wdata;
  logic                           f4, f5, f6;

  assign item_xfer = item_i.valid && item_i.ready;
  assign pkt_xfer  = pkt_o.valid && pkt_o.ready;
  assign cfg_xfer  = cfg_i.valid && cfg_i.ready;

  assign item_i.ready = (state_q == StIdle);
  assign cfg_i.ready  = 1'b1;

  assign pkt_o.valid         = (state_q == StOut);
  assign pkt_o.packet_byte   = rd_q;
  assign pkt_o.byte_position = idx_q;
  assign pkt_o.radio_channel = chan_q;
  assign pkt_o.last_byte     = (idx_q == LastPos);
  assign pkt_o.bind_finished = fin_q;
  assign pkt_o.power_refresh = ref_q;

  // shared unit: magnitude times scaled reciprocal gives the quotient
  assign ch_sel    = ch_q[ch_idx_q];
  assign mag       = ch_sel[14] ? 15'(~ch_sel + 15'd1) : ch_sel;
  assign prod_full = {{RecipW{1'b0}}, mag} * {{MagW{1'b0}}, Recip};

  assign q_s   = neg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
  assign v_s   = q_s + 25'sd1497;
  assign blank = ({1'b0, ch_idx_q} >= active_q);

  always_comb begin
    if (blank) begin
      word_d = 16'd0;
    end else if (v_s < 0) begin
      word_d = 16'd0;
    end else if (v_s > 25'sd65535) begin
      word_d = 16'hFFFF;
    end else begin
      word_d = v_s[15:0];
    end
  end

  assign f4 = (ch_q[4] > 15'sd400);
  assign f5 = (ch_q[5] > 15'sd400);
  assign f6 = (ch_q[6] > 15'sd400);

  always_comb begin
    case (idx_q[2:0])
      3'd0:    wbase = bind_q ? rchop_pkg::HdrBind : rchop_pkg::HdrData;
      3'd1:    wbase = id_q[7:0];
      3'd2:    wbase = id_q[15:8];
      3'd3:    wbase = id_q[23:16];
      default: wbase = id_q[31:24];
    endcase
    if (state_q == StWlo) begin
      wbase = word_q[7:0];
    end else if (state_q == StWhi) begin
      wbase = word_q[15:8];
    end
    wdata = wbase;
    if (mod_q && idx_q == FlagByteA) begin
      wdata = wbase | {f6, f5, 6'd0};
    end
    if (mod_q && idx_q == FlagByteB) begin
      wdata = wbase | {2'd0, f4, 5'd0};
    end
  end

  assign we = (state_q == StHdr) || (state_q == StWlo) || (state_q == StWhi);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    if (state_q == StRd) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      id_q         <= '0;
      fixed_q      <= 1'b0;
      active_q     <= 4'd8;
      mod_q        <= 1'b0;
      bind_count_q <= 16'd2500;
      row_q        <= '0;
      col_q        <= '0;
      off_q        <= '0;
      bind_left_q  <= '0;
      for (int i = 0; i < rchop_pkg::NumChan; i++) begin
        ch_q[i] <= '0;
      end
      bind_q       <= 1'b0;
      fin_q        <= 1'b0;
      ref_q        <= 1'b0;
      chan_q       <= '0;
      idx_q        <= '0;
      ch_idx_q     <= '0;
      prod_q       <= '0;
      neg_q        <= 1'b0;
      word_q       <= '0;
    end else begin
      if (cfg_xfer) begin
        unique case (cfg_i.index)
          rchop_pkg::RegDeviceId:       id_q         <= cfg_i.data;
          rchop_pkg::RegFixedIdSet:     fixed_q      <= cfg_i.data[0];
          rchop_pkg::RegActiveChannels: active_q     <= cfg_i.data[3:0];
          rchop_pkg::RegModMode:        mod_q        <= cfg_i.data[0];
          rchop_pkg::RegBindCount:      bind_count_q <= cfg_i.data[15:0];
          default: ;
        endcase
      end

      unique case (state_q)
        StIdle: begin
          if (item_xfer && !item_i.kind) begin
            row_q <= id_q[3:0];
            col_q <= '0;
            off_q <= id_q[7:4];
            bind_left_q <= (item_i.bind_request || !fixed_q) ? bind_count_q : 16'd0;
          end else if (item_xfer) begin
            ch_q[0] <= item_i.channel_0;
            ch_q[1] <= item_i.channel_1;
            ch_q[2] <= item_i.channel_2;
            ch_q[3] <= item_i.channel_3;
            ch_q[4] <= item_i.channel_4;
            ch_q[5] <= item_i.channel_5;
            ch_q[6] <= item_i.channel_6;
            ch_q[7] <= item_i.channel_7;
            idx_q   <= '0;
            if (bind_left_q != 16'd0) begin
              bind_q      <= 1'b1;
              chan_q      <= 8'd1;
              bind_left_q <= bind_left_q - 16'd1;
              fin_q       <= (bind_left_q == 16'd1);
              ref_q       <= 1'b0;
            end else begin
              bind_q <= 1'b0;
              chan_q <= rchop_pkg::HopTable[{row_q, col_q}] - {4'd0, off_q};
              col_q  <= col_q + 4'd1;
              ref_q  <= (col_q == 4'hF);
              fin_q  <= 1'b0;
            end
            state_q <= StHdr;
          end
        end
        StHdr: begin
          idx_q <= idx_q + 5'd1;
          if (idx_q == HdrLast) begin
            ch_idx_q <= '0;
            state_q  <= StMul;
          end
        end
        StMul: begin
          prod_q  <= ProdW'(prod_full >> Shift);
          neg_q   <= ch_sel[14];
          state_q <= StFin;
        end
        StFin: begin
          word_q  <= word_d;
          state_q <= StWlo;
        end
        StWlo: begin
          idx_q   <= idx_q + 5'd1;
          state_q <= StWhi;
        end
        StWhi: begin
          if (ch_idx_q == 3'd7) begin
            idx_q   <= '0;
            state_q <= StRd;
          end else begin
            idx_q    <= idx_q + 5'd1;
            ch_idx_q <= ch_idx_q + 3'd1;
            state_q  <= StMul;
          end
        end
        StRd: begin
          state_q <= StOut;
        end
        StOut: begin
          if (pkt_xfer) begin
            if (idx_q == LastPos) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + 5'd1;
              state_q <= StRd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== bench/rc_hopping_packet_transmitter_test.sv =====
// ----------------------------------------------------------------------------
// rc_hopping_packet_transmitter_test
// Self-checking bench for the hopping packet transmitter. A queue of start
// items and slot ticks feeds a clocked driver. A clocked monitor compares
// every packet byte with a local model of the packet framing, the bind
// counter and the hop sequence. Both sides insert random gaps and stalls outside the steady phase.
// ----------------------------------------------------------------------------
module rc_hopping_packet_transmitter_test;

  localparam int FullScale = 10000;
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef struct {
    logic             kind;
    logic             bind_request;
    rchop_pkg::chan_t ch [rchop_pkg::NumChan];
    logic             hold;
  } slot_t;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] pos;
    logic [7:0] rf_chan;
    logic       last;
    logic       bind_done;
    logic       refresh;
  } pkt_byte_t;

  logic clk_i;
  logic rst_ni;

  rchop_item_if item_if ();
  rchop_pkt_if  pkt_if ();
  rchop_cfg_if  cfg_if ();

  rc_hopping_packet_transmitter #(
    .CHAN_FULL_SCALE(FullScale)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .pkt_o  (pkt_if),
    .cfg_i  (cfg_if)
  );

  // register copies
  logic [31:0] cfg_device_id;
  logic        cfg_fixed_id;
  logic [3:0]  cfg_active;
  logic        cfg_mod;
  logic [15:0] cfg_bind_count;

  // hop and bind state
  logic [3:0]  hop_row;
  logic [3:0]  hop_col;
  logic [3:0]  hop_offset;
  logic [15:0] bind_left;

  slot_t       slot_queue [$];
  pkt_byte_t   expected_bytes [$];
  slot_t       cur_slot;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned error_count;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] stick_to_pulse(rchop_pkg::chan_t ch);
    int v;
    v = int'(ch) * 'sh1F1 / FullScale + 'sh5D9;
    if (v < 0) v = 0;
    if (v > 'shFFFF) v = 'shFFFF;
    return v[15:0];
  endfunction

  // advance hop and bind state for one accepted item, queue a tick's packet bytes
  function automatic void frame_slot(slot_t s);
    logic [7:0]  frame [rchop_pkg::PacketLen];
    logic [15:0] word;
    logic        binding;
    logic        bind_done;
    logic        refresh;
    logic [7:0]  rf_chan;
    pkt_byte_t   b;
    if (s.kind == KindStart) begin
      hop_row    = cfg_device_id[3:0];
      hop_col    = '0;
      hop_offset = cfg_device_id[7:4];
      bind_left  = (s.bind_request || !cfg_fixed_id) ? cfg_bind_count : '0;
      return;
    end
    binding  = bind_left != 0;
    frame[0] = binding ? rchop_pkg::HdrBind : rchop_pkg::HdrData;
    for (int i = 0; i < 4; i++) frame[1 + i] = cfg_device_id[8*i +: 8];
    for (int i = 0; i < rchop_pkg::NumChan; i++) begin
      word = (i >= int'(cfg_active)) ? 16'h0 : stick_to_pulse(s.ch[i]);
      frame[5 + 2*i] = word[7:0];
      frame[6 + 2*i] = word[15:8];
    end
    if (cfg_mod) begin
      if (int'(s.ch[4]) > 400) frame[12] |= 8'h20;
      if (int'(s.ch[5]) > 400) frame[10] |= 8'h40;
      if (int'(s.ch[6]) > 400) frame[10] |= 8'h80;
    end
    bind_done = 1'b0;
    refresh   = 1'b0;
    if (binding) begin
      rf_chan   = 8'd1;
      bind_left = bind_left - 16'd1;
      bind_done = bind_left == 0;
    end else begin
      rf_chan = rchop_pkg::HopTable[{hop_row, hop_col}] - {4'd0, hop_offset};
      hop_col = hop_col + 4'd1;
      refresh = hop_col == 0;
    end
    for (int k = 0; k < rchop_pkg::PacketLen; k++) begin
      b.data      = frame[k];
      b.pos       = k[4:0];
      b.rf_chan   = rf_chan;
      b.last      = k == rchop_pkg::PacketLen - 1;
      b.bind_done = bind_done;
      b.refresh   = refresh;
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic rchop_pkg::chan_t pick_value();
    case ($urandom_range(0, 5))
      0: return rchop_pkg::chan_t'(-16384);
      1: return rchop_pkg::chan_t'(16383);
      2: return rchop_pkg::chan_t'(399 + $urandom_range(0, 2));
      3: return rchop_pkg::chan_t'(int'($urandom_range(0, 100)) - 50);
      default: return rchop_pkg::chan_t'($urandom());
    endcase
  endfunction

  function automatic slot_t make_slot(logic kind, logic bind_request);
    slot_t s;
    s.kind         = kind;
    s.bind_request = bind_request;
    s.hold         = 1'b0;
    for (int i = 0; i < rchop_pkg::NumChan; i++) s.ch[i] = pick_value();
    return s;
  endfunction

  function automatic slot_t fill_slot(int value);
    slot_t s;
    s = make_slot(KindTick, 1'b0);
    for (int i = 0; i < rchop_pkg::NumChan; i++) s.ch[i] = rchop_pkg::chan_t'(value);
    return s;
  endfunction

  task automatic write_reg(input logic [rchop_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    case (idx)
      rchop_pkg::RegDeviceId:       cfg_device_id  = val;
      rchop_pkg::RegFixedIdSet:     cfg_fixed_id   = val[0];
      rchop_pkg::RegActiveChannels: cfg_active     = val[3:0];
      rchop_pkg::RegModMode:        cfg_mod        = val[0];
      rchop_pkg::RegBindCount:      cfg_bind_count = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] id, input logic fixed, input logic [3:0] active,
                           input logic mod_on, input logic [15:0] count);
    write_reg(rchop_pkg::RegDeviceId, id);
    write_reg(rchop_pkg::RegFixedIdSet, {31'd0, fixed});
    write_reg(rchop_pkg::RegActiveChannels, {28'd0, active});
    write_reg(rchop_pkg::RegModMode, {31'd0, mod_on});
    write_reg(rchop_pkg::RegBindCount, {16'd0, count});
  endtask

  // wait for every queued item and expected byte, then let the block go idle
  task automatic drain();
    do @(posedge clk_i);
    while (slot_queue.size() != 0 || item_if.valid || expected_bytes.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // item driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        frame_slot(cur_slot);
        gap_left = steady ? 0 : $urandom_range(0, 6);
      end
      if (!(item_if.valid && !item_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (slot_queue.size() != 0 &&
                     !(slot_queue[0].hold && expected_bytes.size() != 0)) begin
          cur_slot = slot_queue.pop_front();
          item_if.kind         <= cur_slot.kind;
          item_if.bind_request <= cur_slot.bind_request;
          item_if.channel_0    <= cur_slot.ch[0];
          item_if.channel_1    <= cur_slot.ch[1];
          item_if.channel_2    <= cur_slot.ch[2];
          item_if.channel_3    <= cur_slot.ch[3];
          item_if.channel_4    <= cur_slot.ch[4];
          item_if.channel_5    <= cur_slot.ch[5];
          item_if.channel_6    <= cur_slot.ch[6];
          item_if.channel_7    <= cur_slot.ch[7];
          item_if.valid        <= 1'b1;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // packet byte monitor
  always @(posedge clk_i) begin
    pkt_byte_t got;
    pkt_byte_t want;
    if (!rst_ni) begin
      pkt_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) begin
        got = '{pkt_if.packet_byte, pkt_if.byte_position, pkt_if.radio_channel,
                pkt_if.last_byte, pkt_if.bind_finished, pkt_if.power_refresh};
        if (expected_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transfer, actual byte %h pos %0d chan %h flags %b%b%b",
                   $time, got.data, got.pos, got.rf_chan, got.last, got.bind_done,
                   got.refresh);
        end else begin
          want = expected_bytes.pop_front();
          if (got.data != want.data || got.pos != want.pos || got.rf_chan != want.rf_chan ||
              got.last != want.last || got.bind_done != want.bind_done ||
              got.refresh != want.refresh) begin
            error_count++;
            $display({"%0t: expected byte %h pos %0d chan %h last/bind/refresh %b%b%b,",
                      " actual byte %h pos %0d chan %h last/bind/refresh %b%b%b"},
                     $time, want.data, want.pos, want.rf_chan, want.last, want.bind_done,
                     want.refresh, got.data, got.pos, got.rf_chan, got.last,
                     got.bind_done, got.refresh);
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        pkt_if.ready <= 1'b0;
      end else begin
        pkt_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    slot_t s;
    int    n;
    rst_ni               = 1'b0;
    error_count          = 0;
    steady               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.kind         = KindStart;
    item_if.bind_request = 1'b0;
    item_if.channel_0    = '0;
    item_if.channel_1    = '0;
    item_if.channel_2    = '0;
    item_if.channel_3    = '0;
    item_if.channel_4    = '0;
    item_if.channel_5    = '0;
    item_if.channel_6    = '0;
    item_if.channel_7    = '0;
    pkt_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    cfg_device_id        = '0;
    cfg_fixed_id         = 1'b0;
    cfg_active           = 4'd8;
    cfg_mod              = 1'b0;
    cfg_bind_count       = 16'd2500;
    hop_row              = '0;
    hop_col              = '0;
    hop_offset           = '0;
    bind_left            = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short bind run, then a full hop cycle on row 15 with offset 15
    write_all(32'hFFFF_FFFF, 1'b1, 4'd8, 1'b1, 16'd2);
    slot_queue.push_back(make_slot(KindStart, 1'b1));
    slot_queue.push_back(fill_slot(16383));
    slot_queue.push_back(fill_slot(-16384));
    slot_queue.push_back(make_slot(KindStart, 1'b0));
    s = fill_slot(0);
    s.ch[4] = rchop_pkg::chan_t'(401);
    s.ch[5] = rchop_pkg::chan_t'(400);
    s.ch[6] = rchop_pkg::chan_t'(401);
    slot_queue.push_back(s);
    s.ch[4] = rchop_pkg::chan_t'(400);
    s.ch[5] = rchop_pkg::chan_t'(401);
    s.ch[6] = rchop_pkg::chan_t'(400);
    s.hold  = 1'b1;
    slot_queue.push_back(s);
    for (int i = 0; i < 14; i++) slot_queue.push_back(make_slot(KindTick, 1'b0));
    drain();

    // zero bind count, all channels blanked, flags still set
    write_all(32'h0000_0000, 1'b0, 4'd0, 1'b1, 16'd0);
    slot_queue.push_back(make_slot(KindStart, 1'b0));
    slot_queue.push_back(fill_slot(16383));
    drain();

    // active count above eight, longest bind count
    write_all(32'h8000_0000, 1'b1, 4'd15, 1'b0, 16'hFFFF);
    slot_queue.push_back(make_slot(KindStart, 1'b1));
    slot_queue.push_back(fill_slot(-16384));
    slot_queue.push_back(make_slot(KindStart, 1'b0));
    slot_queue.push_back(fill_slot(16383));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      steady = phase == 2;
      write_all($urandom(), 1'($urandom_range(0, 1)),
                (phase == 0) ? 4'd8 : 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)),
                (phase == 4) ? 16'hFFFF :
                (phase == 5) ? 16'd0 : 16'($urandom_range(1, 6)));
      if (phase == 4) write_reg(rchop_pkg::RegFixedIdSet, 32'd1);
      n = 0;
      slot_queue.push_back(make_slot(KindStart, phase != 4));
      while (n < 21) begin
        if ($urandom_range(0, 9) == 0)
          s = make_slot(KindStart, (phase == 4) ? 1'b0 : 1'($urandom_range(0, 1)));
        else
          s = make_slot(KindTick, 1'($urandom_range(0, 1)));
        s.hold = $urandom_range(0, 19) == 0;
        slot_queue.push_back(s);
        n++;
      end
      drain();
    end
    steady = 1'b0;

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("rc_hopping_packet_transmitter: match");
    end else begin
      $display("rc_hopping_packet_transmitter: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rc_hopping_packet_transmitter: mismatch");
    $finish;
  end

endmodule
